### rtl/cps_pkg.sv
// shared types and constants of the companion power sequencer
`default_nettype none
package cps_pkg;

  localparam int TimerBits  = 16;
  localparam int OpcodeBits = 32;
  localparam int MaxRes     = 16;
  localparam int CntBits    = $clog2(MaxRes + 1);
  localparam int IdxBits    = $clog2(MaxRes);
  localparam int QueueDepth = 2;

  typedef enum logic [2:0] {
    EvTick      = 3'd0,
    EvPowerCmd  = 3'd1,
    EvModeCmd   = 3'd2,
    EvStateRpt  = 3'd3,
    EvModeRpt   = 3'd4,
    EvLocalMode = 3'd5,
    EvLink      = 3'd6,
    EvExtOff    = 3'd7
  } event_e;

  typedef enum logic [2:0] {
    KindResp     = 3'd0,
    KindGpio     = 3'd1,
    KindModeReq  = 3'd2,
    KindGraceful = 3'd3,
    KindStateRpt = 3'd4,
    KindTrusted  = 3'd5
  } kind_e;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StBusy    = 2'd1;
  localparam logic [1:0] StValErr  = 2'd2;
  localparam logic [1:0] StExecErr = 2'd3;

  localparam logic [1:0] PwrOff = 2'd0;
  localparam logic [1:0] PwrOn  = 2'd1;

  localparam logic [1:0] RegCmdTimeout = 2'd0;
  localparam logic [1:0] RegOffDelay   = 2'd1;
  localparam logic [1:0] RegGraceful   = 2'd2;
  localparam logic [1:0] RegModePath   = 2'd3;

  typedef struct packed {
    logic [2:0]            cmd;
    logic [OpcodeBits-1:0] opcode;
    logic [31:0]           sequence_req;
    logic [1:0]            power_state;
    logic [3:0]            power_mode;
    logic                  authorized;
    logic                  link_ok;
  } in_t;

  typedef struct packed {
    logic [2:0]            kind;
    logic [OpcodeBits-1:0] resp_opcode;
    logic [31:0]           resp_sequence;
    logic [1:0]            resp_status;
    logic                  level;
    logic [3:0]            mode_value;
    logic                  last;
  } res_t;

  // classified event from the front to the back
  typedef struct packed {
    event_e ev;
    in_t    item;
  } evt_t;

endpackage
`default_nettype wire

### rtl/companion_power_sequencer_top.sv
// Companion power sequencer, top level.
// Input channel: an event beat is taken when push_i is high and full_o low;
// a two-entry queue sits in front, so events are taken while results wait.
// Result channel: the oldest result is on res_o while empty_o is low and is
// taken when pop_i is high; res_o.last marks the final result of an event.
// Each event is executed once all results of the previous event are popped;
// its results (zero to sixteen) then drain one per cycle while pop_i is high.
// The first result is on res_o once the event has passed the input queue
// register and been written into the result buffer; it can then be popped.
// If the receiver stalls, results hold on res_o and the input queue fills,
// raising full_o. Configuration: cfg_we_i with cfg_idx_i and cfg_data_i
// writes one register; write only while the block is idle.
// Reset clears the queues, all bookkeeping and timers, and loads register
// defaults (timeout 30, off delay 5, both remote paths present).
`default_nettype none
module companion_power_sequencer_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire cps_pkg::in_t  in_i,
  output logic               full_o,
  output logic               empty_o,
  output cps_pkg::res_t      res_o,
  input  wire logic          pop_i,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_idx_i,
  input  wire logic [15:0]   cfg_data_i
);
  import cps_pkg::*;

  evt_t evt;
  logic evt_valid, evt_take;

  cps_front u_front (
    .clk_i, .rst_ni, .push_i, .in_i, .full_o,
    .evt_valid_o (evt_valid),
    .evt_o       (evt),
    .evt_take_i  (evt_take)
  );

  cps_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .evt_valid_i (evt_valid),
    .evt_i       (evt),
    .evt_take_o  (evt_take),
    .empty_o, .res_o, .pop_i
  );

endmodule
`default_nettype wire

### rtl/cps_front.sv
// front end: input queue and event classification
`default_nettype none
module cps_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire cps_pkg::in_t in_i,
  output logic              full_o,
  output logic              evt_valid_o,
  output cps_pkg::evt_t     evt_o,
  input  wire logic         evt_take_i
);
  import cps_pkg::*;

  localparam int PtrBits = $clog2(QueueDepth);

  in_t                 q_mem [QueueDepth];
  logic [PtrBits-1:0]  wr_q, rd_q;
  logic [PtrBits:0]    cnt_q;
  logic                do_push, do_pop;

  assign full_o      = (cnt_q == (PtrBits+1)'(QueueDepth));
  assign evt_valid_o = (cnt_q != '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = evt_take_i && evt_valid_o;

  always_comb begin
    evt_o.item = q_mem[rd_q];
    evt_o.ev   = event_e'(q_mem[rd_q].cmd);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_q] <= in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrBits+1)'(do_push) - (PtrBits+1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

### rtl/cps_back.sv
// back end: event execution, sequencer state and result buffer
`default_nettype none
module cps_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_idx_i,
  input  wire logic [15:0]   cfg_data_i,
  input  wire logic          evt_valid_i,
  input  wire cps_pkg::evt_t evt_i,
  output logic               evt_take_o,
  output logic               empty_o,
  output cps_pkg::res_t      res_o,
  input  wire logic          pop_i
);
  import cps_pkg::*;

  typedef struct packed {
    logic                  mode_pend;
    logic                  mode_ans;
    logic [OpcodeBits-1:0] mode_op;
    logic [31:0]           mode_seq;
    logic [3:0]            req_mode;
    logic [TimerBits-1:0]  mode_tmr;
    logic                  pwr_pend;
    logic                  pwr_known;
    logic                  wait_cut;
    logic                  pwr_ans;
    logic [OpcodeBits-1:0] pwr_op;
    logic [31:0]           pwr_seq;
    logic [1:0]            req_pwr;
    logic [1:0]            cur_pwr;
    logic [TimerBits-1:0]  pwr_tmr;
    logic [TimerBits-1:0]  cut_tmr;
    logic [TimerBits-1:0]  boot_tmr;
    logic                  await_boot;
    logic                  def_off;
    logic                  link_up;
  } st_t;

  typedef struct packed {
    logic [TimerBits-1:0] cmd_to;
    logic [TimerBits-1:0] off_dly;
    logic                 graceful;
    logic                 mode_path;
  } cfg_t;

  typedef struct packed {
    st_t                      s;
    logic [CntBits-1:0]       n;
    res_t [MaxRes-1:0]        res;
  } ctx_t;

  // no mode requested after reset
  localparam st_t StRst = '{req_mode: 4'd15, default: '0};

  st_t                 st_q;
  cfg_t                cfg_q;
  res_t                buf_q [MaxRes];
  logic [CntBits-1:0]  cnt_q, rd_q;
  ctx_t                nx;

  function automatic ctx_t emit(ctx_t c, kind_e k, logic [OpcodeBits-1:0] op,
                                logic [31:0] sq, logic [1:0] stat, logic lvl,
                                logic [3:0] mv);
    res_t r;
    r.kind          = k;
    r.resp_opcode   = op;
    r.resp_sequence = sq;
    r.resp_status   = stat;
    r.level         = lvl;
    r.mode_value    = mv;
    r.last          = 1'b0;
    if (c.n < CntBits'(MaxRes)) begin
      c.res[c.n[IdxBits-1:0]] = r;
      c.n = c.n + 1'b1;
    end
    return c;
  endfunction

  function automatic logic trusted(st_t s);
    return s.pwr_known && (s.cur_pwr == PwrOn) && !s.await_boot &&
           !s.mode_pend && s.link_up;
  endfunction

  function automatic ctx_t cut_power(ctx_t c);
    c = emit(c, KindGpio, '0, '0, StOk, 1'b0, 4'd0);
    c.s.cur_pwr    = PwrOff;
    c.s.pwr_known  = 1'b1;
    c.s.await_boot = 1'b0;
    c.s.boot_tmr   = '0;
    c = emit(c, KindStateRpt, '0, '0, StOk, 1'b0, 4'd0);
    return c;
  endfunction

  function automatic ctx_t finish_power(ctx_t c);
    if (c.s.pwr_ans) c = emit(c, KindResp, c.s.pwr_op, c.s.pwr_seq, StOk, 1'b0, 4'd0);
    c.s.pwr_pend = 1'b0;
    c.s.pwr_tmr  = '0;
    c.s.wait_cut = 1'b0;
    c.s.cut_tmr  = '0;
    return c;
  endfunction

  function automatic ctx_t begin_off(ctx_t c, cfg_t g);
    c.s.req_pwr  = PwrOff;
    c.s.pwr_pend = 1'b1;
    c.s.pwr_tmr  = '0;
    c.s.wait_cut = 1'b0;
    c.s.cut_tmr  = '0;
    if (c.s.await_boot || c.s.mode_pend) begin
      c.s.def_off = 1'b1;
    end else begin
      c.s.def_off = 1'b0;
      if (trusted(c.s) && g.graceful) begin
        c = emit(c, KindGraceful, '0, '0, StOk, 1'b0, 4'd0);
      end else begin
        c = cut_power(c);
        c = finish_power(c);
      end
    end
    return c;
  endfunction

  always_comb begin
    in_t  it;
    logic boot_was;
    it       = evt_i.item;
    nx.s     = st_q;
    nx.n     = '0;
    nx.res   = '0;
    boot_was = st_q.await_boot;
    case (evt_i.ev)
      EvTick: begin
        nx = emit(nx, KindTrusted, '0, '0, StOk, trusted(nx.s), 4'd0);
        if (nx.s.await_boot) begin
          nx.s.boot_tmr = nx.s.boot_tmr + 1'b1;
          if (nx.s.boot_tmr >= cfg_q.cmd_to) begin
            nx.s.await_boot = 1'b0;
            nx.s.boot_tmr   = '0;
            if (nx.s.def_off) nx = begin_off(nx, cfg_q);
          end
        end
        if (nx.s.mode_pend) begin
          nx.s.mode_tmr = nx.s.mode_tmr + 1'b1;
          if (nx.s.mode_tmr >= cfg_q.cmd_to) begin
            if (nx.s.mode_ans) begin
              nx = emit(nx, KindResp, nx.s.mode_op, nx.s.mode_seq, StExecErr, 1'b0, 4'd0);
            end
            nx.s.mode_pend = 1'b0;
            nx.s.mode_tmr  = '0;
            if (nx.s.def_off) nx = begin_off(nx, cfg_q);
          end
        end
        if (nx.s.wait_cut) begin
          nx.s.cut_tmr = nx.s.cut_tmr + 1'b1;
          if (nx.s.cut_tmr >= cfg_q.off_dly) begin
            nx = cut_power(nx);
            nx = finish_power(nx);
          end
        end
        if (nx.s.pwr_pend && !nx.s.wait_cut && !nx.s.def_off) begin
          nx.s.pwr_tmr = nx.s.pwr_tmr + 1'b1;
          if (nx.s.pwr_tmr >= cfg_q.cmd_to) begin
            if (nx.s.req_pwr == PwrOff) nx = cut_power(nx);
            nx = finish_power(nx);
          end
        end
      end
      EvPowerCmd: begin
        if (!it.authorized) begin
          nx = emit(nx, KindResp, it.opcode, it.sequence_req, StValErr, 1'b0, 4'd0);
        end else if (nx.s.pwr_pend) begin
          nx = emit(nx, KindResp, it.opcode, it.sequence_req, StBusy, 1'b0, 4'd0);
        end else begin
          nx.s.pwr_op   = it.opcode;
          nx.s.pwr_seq  = it.sequence_req;
          nx.s.req_pwr  = it.power_state;
          nx.s.pwr_pend = 1'b1;
          nx.s.pwr_tmr  = '0;
          nx.s.wait_cut = 1'b0;
          nx.s.cut_tmr  = '0;
          nx.s.pwr_ans  = 1'b1;
          if (it.power_state == PwrOn) begin
            nx = emit(nx, KindGpio, '0, '0, StOk, 1'b1, 4'd0);
            nx.s.await_boot = !(nx.s.pwr_known && nx.s.cur_pwr == PwrOn);
            nx.s.boot_tmr   = '0;
            nx.s.pwr_pend   = 1'b0;
            nx = emit(nx, KindResp, it.opcode, it.sequence_req, StOk, 1'b0, 4'd0);
          end else if (it.power_state == PwrOff) begin
            nx = begin_off(nx, cfg_q);
          end else begin
            nx = emit(nx, KindResp, it.opcode, it.sequence_req, StValErr, 1'b0, 4'd0);
            nx.s.pwr_pend = 1'b0;
          end
        end
      end
      EvModeCmd: begin
        if (nx.s.mode_pend) begin
          nx = emit(nx, KindResp, it.opcode, it.sequence_req, StBusy, 1'b0, 4'd0);
        end else if (!trusted(nx.s) || !cfg_q.mode_path) begin
          nx = emit(nx, KindResp, it.opcode, it.sequence_req, StValErr, 1'b0, 4'd0);
        end else begin
          nx.s.mode_op   = it.opcode;
          nx.s.mode_seq  = it.sequence_req;
          nx.s.req_mode  = it.power_mode;
          nx.s.mode_pend = 1'b1;
          nx.s.mode_ans  = 1'b1;
          nx.s.mode_tmr  = '0;
          nx = emit(nx, KindModeReq, '0, '0, StOk, 1'b0, it.power_mode);
        end
      end
      EvStateRpt: begin
        nx.s.cur_pwr    = it.power_state;
        nx.s.pwr_known  = 1'b1;
        nx.s.await_boot = 1'b0;
        nx.s.boot_tmr   = '0;
        nx = emit(nx, KindStateRpt, '0, '0, StOk, it.power_state == PwrOn, 4'd0);
        if (boot_was && nx.s.def_off) begin
          nx = begin_off(nx, cfg_q);
        end else if (nx.s.pwr_pend && it.power_state == nx.s.req_pwr &&
                     it.power_state == PwrOff) begin
          nx.s.wait_cut = 1'b1;
          nx.s.cut_tmr  = '0;
        end
      end
      EvModeRpt: begin
        if (nx.s.mode_pend && !(nx.s.mode_ans && it.power_mode != nx.s.req_mode)) begin
          if (nx.s.mode_ans) begin
            nx = emit(nx, KindResp, nx.s.mode_op, nx.s.mode_seq, StOk, 1'b0, 4'd0);
          end
          nx.s.mode_pend = 1'b0;
          nx.s.mode_tmr  = '0;
          if (nx.s.def_off) nx = begin_off(nx, cfg_q);
        end
      end
      EvLocalMode: begin
        if (!nx.s.mode_pend) begin
          nx.s.mode_pend = 1'b1;
          nx.s.mode_ans  = 1'b0;
          nx.s.mode_tmr  = '0;
        end
      end
      EvLink: begin
        nx.s.link_up = it.link_ok;
      end
      default: begin
        if (it.power_state == PwrOff) begin
          nx.s.pwr_op  = '0;
          nx.s.pwr_seq = '0;
          nx.s.pwr_ans = 1'b0;
          nx.s.req_pwr = PwrOff;
          nx = begin_off(nx, cfg_q);
        end
      end
    endcase
  end

  // next event runs once every beat of the previous one is gone
  assign empty_o    = (rd_q == cnt_q);
  assign evt_take_o = evt_valid_i && empty_o;

  always_comb begin
    res_o      = buf_q[rd_q[IdxBits-1:0]];
    res_o.last = (rd_q + 1'b1 == cnt_q);
  end

  always_ff @(posedge clk_i) begin
    if (evt_take_o) begin
      for (int i = 0; i < MaxRes; i++) buf_q[i] <= nx.res[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q           <= StRst;
      cfg_q.cmd_to   <= TimerBits'(30);
      cfg_q.off_dly  <= TimerBits'(5);
      cfg_q.graceful <= 1'b1;
      cfg_q.mode_path <= 1'b1;
      cnt_q          <= '0;
      rd_q           <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegCmdTimeout: cfg_q.cmd_to    <= cfg_data_i[TimerBits-1:0];
          RegOffDelay:   cfg_q.off_dly   <= cfg_data_i[TimerBits-1:0];
          RegGraceful:   cfg_q.graceful  <= cfg_data_i[0];
          RegModePath:   cfg_q.mode_path <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (evt_take_o) begin
        st_q  <= nx.s;
        cnt_q <= nx.n;
        rd_q  <= '0;
      end else if (pop_i && !empty_o) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  a_rd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_q <= cnt_q) else $error("read index past fill");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntBits'(MaxRes)) else $error("result count overflow");
  a_take_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_take_o |=> rd_q == '0) else $error("read index not restarted");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> !evt_take_o) else $error("event taken while beats wait");

endmodule
`default_nettype wire
